### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the rectangle space transform.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RSTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RSTU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RSTU_ASSERT(lbl, prop, msg)
`define RSTU_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/rstu_pkg.sv
// Shared types and constants for the rectangle space transform.
// No dependencies.
package rstu_pkg;

    localparam int KW = 24;    // length factor width, Q8.16
    localparam int RIW = 3;    // register index width

    typedef enum logic [2:0] {
        M_LOW          = 3'd0,
        M_HIGH         = 3'd1,
        M_CENTER       = 3'd2,
        M_SCALE_LOW    = 3'd3,
        M_SCALE_HIGH   = 3'd4,
        M_SCALE_CENTER = 3'd5
    } method_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_METHOD = 2'd1,
        ST_ZERO_SRC   = 2'd2
    } status_t;

    typedef enum logic [RIW-1:0] {
        R_SRC_LEFT   = 3'd0,
        R_SRC_TOP    = 3'd1,
        R_SRC_RIGHT  = 3'd2,
        R_SRC_BOTTOM = 3'd3,
        R_DST_LEFT   = 3'd4,
        R_DST_TOP    = 3'd5,
        R_DST_RIGHT  = 3'd6,
        R_DST_BOTTOM = 3'd7
    } reg_idx_t;

    localparam logic [63:0] RST_RIGHT  = 64'd41943040;
    localparam logic [63:0] RST_BOTTOM = 64'd31457280;

    typedef struct packed {
        logic bad_method;
        logic scale_zero;
    } lane_flags_t;

endpackage

### rtl/core/rstu_div.sv
// Pipelined signed floor divider, one quotient bit per stage.
// Depends on nothing; used by rstu_lane.
module rstu_div #(
    parameter int NW = 68,
    parameter int DW = 34
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [NW:0]   quo
);

    logic [DW-1:0] rem_reg [0:NW];
    logic [NW-1:0] dq_reg  [0:NW];
    logic [DW-1:0] dd_reg  [0:NW];
    logic          neg_reg [0:NW];
    logic [DW-1:0] rem_nx  [1:NW];
    logic          ge_nx   [1:NW];
    logic signed [NW:0] quo_reg;
    logic signed [NW:0] qpos;

    for (genvar i = 1; i <= NW; i++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        assign trial     = {rem_reg[i-1], dq_reg[i-1][NW-1]};
        assign ge_nx[i]  = trial >= {1'b0, dd_reg[i-1]};
        assign diff      = ge_nx[i] ? (trial - {1'b0, dd_reg[i-1]}) : trial;
        assign rem_nx[i] = diff[DW-1:0];
    end

    // magnitudes and result sign, then one restoring step per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= num[NW-1] ? (~num + 1'b1) : num;
            dd_reg[0]  <= den[DW-1] ? (~den + 1'b1) : den;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            for (int i = 1; i <= NW; i++)
            begin
                rem_reg[i] <= rem_nx[i];
                dq_reg[i]  <= {dq_reg[i-1][NW-2:0], ge_nx[i]};
                dd_reg[i]  <= dd_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // round toward minus infinity for a negative result with remainder
    assign qpos = signed'({1'b0, dq_reg[NW]}) + signed'({{NW{1'b0}}, |rem_reg[NW]});

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= neg_reg[NW] ? -qpos : signed'({1'b0, dq_reg[NW]});
    end

    assign quo = quo_reg;

endmodule

### rtl/core/rstu_lane.sv
// One axis of the transform: differences, products, division, placement.
// Depends on rstu_pkg and rstu_div.
module rstu_lane
    import rstu_pkg::*;
#(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] in_lo,
    input  logic signed [CW-1:0] in_hi,
    input  logic signed [CW-1:0] src_lo,
    input  logic signed [CW-1:0] src_hi,
    input  logic signed [CW-1:0] dst_lo,
    input  logic signed [CW-1:0] dst_hi,
    input  logic [2:0]           method,
    input  logic [KW-1:0]        k,
    output logic signed [CW-1:0] out_lo,
    output logic signed [CW-1:0] out_hi,
    output lane_flags_t          flags
);

    localparam int LW   = CW + KW + 2;
    localparam int AW   = CW + KW + 3;
    localparam int PW   = 2 * CW + 4;
    localparam int M1   = (PW + 1 > LW) ? PW + 1 : LW;
    localparam int M2   = (M1 > AW) ? M1 : AW;
    localparam int SW   = M2 + 3;
    localparam int CTXW = LW + AW + (CW + 1) + CW + 3 + 2;
    localparam int DLY  = PW + 2;
    localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // stage 1: differences
    logic signed [CW:0]   s_c, l_c, ss_c, d_c;
    logic signed [CW+1:0] a_c, dv_c;
    logic signed [CW+2:0] n_c;
    lane_flags_t          f_c;

    assign s_c  = (CW+1)'(in_lo) - (CW+1)'(src_lo);
    assign l_c  = (CW+1)'(in_hi) - (CW+1)'(in_lo);
    assign ss_c = (CW+1)'(src_hi) - (CW+1)'(src_lo);
    assign d_c  = (CW+1)'(dst_hi) - (CW+1)'(dst_lo);
    assign dv_c = (CW+2)'(ss_c) + (CW+2)'(ss_c);
    assign a_c  = (method == M_HIGH) ? ((CW+2)'(ss_c) - (CW+2)'(s_c)) : (CW+2)'(s_c);

    always_comb
    begin
        f_c.bad_method = 1'b0;
        f_c.scale_zero = 1'b0;
        n_c = (CW+3)'(s_c) + (CW+3)'(s_c);
        unique case (method_t'(method)) inside
            M_LOW, M_HIGH, M_CENTER: ;
            M_SCALE_LOW:
            begin
                f_c.scale_zero = (ss_c == '0);
            end
            M_SCALE_HIGH:
            begin
                n_c = n_c + (CW+3)'(l_c) + (CW+3)'(l_c);
                f_c.scale_zero = (ss_c == '0);
            end
            M_SCALE_CENTER:
            begin
                n_c = n_c + (CW+3)'(l_c);
                f_c.scale_zero = (ss_c == '0);
            end
            default: f_c.bad_method = 1'b1;
        endcase
    end

    logic signed [CW:0]   l1_reg, d1_reg;
    logic signed [CW+1:0] a1_reg, dv1_reg;
    logic signed [CW+2:0] n1_reg;
    logic signed [CW-1:0] dst1_reg;
    logic [2:0]           m1_reg;
    lane_flags_t          f1_reg;
    logic [KW-1:0]        k1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg   <= l_c;
            d1_reg   <= d_c;
            a1_reg   <= a_c;
            dv1_reg  <= dv_c;
            n1_reg   <= n_c;
            dst1_reg <= dst_lo;
            m1_reg   <= method;
            f1_reg   <= f_c;
            k1_reg   <= k;
        end
    end

    // stage 2: products
    logic signed [KW:0]   kz;
    logic signed [LW-1:0] pl2_reg;
    logic signed [AW-1:0] pa2_reg;
    logic signed [PW-1:0] pn2_reg;
    logic signed [CW+1:0] dv2_reg;
    logic signed [CW:0]   d2_reg;
    logic signed [CW-1:0] dst2_reg;
    logic [2:0]           m2_reg;
    lane_flags_t          f2_reg;

    assign kz = signed'({1'b0, k1_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl2_reg  <= l1_reg * kz;
            pa2_reg  <= a1_reg * kz;
            pn2_reg  <= n1_reg * d1_reg;
            dv2_reg  <= dv1_reg;
            d2_reg   <= d1_reg;
            dst2_reg <= dst1_reg;
            m2_reg   <= m1_reg;
            f2_reg   <= f1_reg;
        end
    end

    // scaled quotient, with the rest of the item riding alongside
    logic signed [PW:0] quo;

    rstu_div #(.NW(PW), .DW(CW + 2)) u_div (
        .clk (clk),
        .en  (en),
        .num (pn2_reg),
        .den (dv2_reg),
        .quo (quo)
    );

    logic signed [LW-1:0] lf2;
    logic signed [AW-1:0] af2;
    logic [CTXW-1:0]      ctx_reg [0:DLY-1];

    assign lf2 = pl2_reg >>> FB;
    assign af2 = pa2_reg >>> FB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= {lf2, af2, d2_reg, dst2_reg, m2_reg, f2_reg};
            for (int i = 1; i < DLY; i++)
                ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    logic signed [LW-1:0] lf_d;
    logic signed [AW-1:0] af_d;
    logic signed [CW:0]   d_d;
    logic signed [CW-1:0] dst_d;
    logic [2:0]           m_d;
    lane_flags_t          f_d;

    assign {lf_d, af_d, d_d, dst_d, m_d, f_d} = ctx_reg[DLY-1];

    // placement of the start point
    logic signed [SW-1:0] q_w, l_w, a_w, d_w, dl_w, st_c;

    assign q_w  = SW'(quo);
    assign l_w  = SW'(lf_d);
    assign a_w  = SW'(af_d);
    assign d_w  = SW'(d_d);
    assign dl_w = d_w - l_w;

    always_comb
    begin
        unique case (method_t'(m_d))
            M_LOW:          st_c = a_w;
            M_HIGH:         st_c = d_w - a_w;
            M_CENTER:       st_c = dl_w >>> 1;
            M_SCALE_LOW:    st_c = q_w;
            M_SCALE_HIGH:   st_c = q_w - l_w;
            M_SCALE_CENTER: st_c = q_w - (l_w >>> 1);
            default:        st_c = '0;
        endcase
    end

    logic signed [SW-1:0] st3_reg, l3_reg;
    logic signed [CW-1:0] dst3_reg;
    lane_flags_t          f3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_reg  <= st_c;
            l3_reg   <= l_w;
            dst3_reg <= dst_d;
            f3_reg   <= f_d;
        end
    end

    // absolute edges, saturated to the coordinate range
    logic signed [SW-1:0] lo_c, hi_c;

    assign lo_c = SW'(dst3_reg) + st3_reg;
    assign hi_c = lo_c + l3_reg;

    logic signed [CW-1:0] out_lo_reg, out_hi_reg;
    lane_flags_t          flags_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_lo_reg <= (lo_c > MAXV) ? MAXV[CW-1:0] :
                          (lo_c < MINV) ? MINV[CW-1:0] : lo_c[CW-1:0];
            out_hi_reg <= (hi_c > MAXV) ? MAXV[CW-1:0] :
                          (hi_c < MINV) ? MINV[CW-1:0] : hi_c[CW-1:0];
            flags_reg  <= f3_reg;
        end
    end

    assign out_lo = out_lo_reg;
    assign out_hi = out_hi_reg;
    assign flags  = flags_reg;

endmodule

### rtl/core/rstu_merge.sv
// Combines the two axis lanes into one result transaction and its status.
// Depends on rstu_pkg.
module rstu_merge
    import rstu_pkg::*;
#(
    parameter int CW = 32,
    parameter int OW = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic signed [CW-1:0] x_lo,
    input  logic signed [CW-1:0] x_hi,
    input  logic signed [CW-1:0] y_lo,
    input  logic signed [CW-1:0] y_hi,
    input  lane_flags_t          fx,
    input  lane_flags_t          fy,
    output logic                 tvalid,
    output logic [OW-1:0]        tdata,
    output logic [1:0]           tuser
);

    status_t       st_c;
    logic [OW-1:0] data_c;

    always_comb
    begin
        if (fx.bad_method || fy.bad_method)
            st_c = ST_BAD_METHOD;
        else if (fx.scale_zero || fy.scale_zero)
            st_c = ST_ZERO_SRC;
        else
            st_c = ST_OK;
        // drop the coordinates of a rejected rectangle
        data_c = (st_c == ST_OK) ? OW'({y_hi, x_hi, y_lo, x_lo}) : '0;
    end

    logic          valid_reg;
    logic [OW-1:0] data_reg;
    status_t       st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_c;
            st_reg   <= st_c;
        end
    end

    assign tvalid = valid_reg;
    assign tdata  = data_reg;
    assign tuser  = st_reg;

endmodule

### rtl/core/rect_space_transform_unit.sv
// Top level of the rectangle space transform: config registers, two axis lanes,
// merge and output register. Depends on rstu_pkg, rstu_lane, rstu_merge.
//
//  channel   | dir | handshake              | contents
//  s_axis    | in  | tvalid/tready          | rectangle, methods, length factor
//  m_axis    | out | tvalid/tready          | transformed rectangle, status in tuser
//  cfg       | in  | cfg_we                 | space edges, index 0..7
//
// One rectangle enters per cycle unless m_axis stalls; most of the pipeline depth
// comes from the bit-per-stage quotient pipeline in each lane.
// The whole pipeline advances unless a result sits unaccepted on m_axis.
// Reset clears the valid line and loads the default space edges.
`include "assert_macros.svh"
module rect_space_transform_unit
    import rstu_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // in_left, in_top, in_right, in_bottom, horiz_method, vert_method, length_factor
    input  logic [((4*COORD_WIDTH+6+KW+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_left, out_top, out_right, out_bottom
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // status
    output logic [1:0]             m_axis_tuser,
    input  logic                   cfg_we,
    input  logic [RIW-1:0]         cfg_addr,
    input  logic [COORD_WIDTH-1:0] cfg_wdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int OW  = ((4*CW+7)/8)*8;
    localparam int PW  = 2 * CW + 4;
    localparam int LAT = PW + 6;

    logic signed [CW-1:0] cfg_reg [0:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[R_SRC_LEFT]   <= '0;
            cfg_reg[R_SRC_TOP]    <= '0;
            cfg_reg[R_SRC_RIGHT]  <= RST_RIGHT[CW-1:0];
            cfg_reg[R_SRC_BOTTOM] <= RST_BOTTOM[CW-1:0];
            cfg_reg[R_DST_LEFT]   <= '0;
            cfg_reg[R_DST_TOP]    <= '0;
            cfg_reg[R_DST_RIGHT]  <= RST_RIGHT[CW-1:0];
            cfg_reg[R_DST_BOTTOM] <= RST_BOTTOM[CW-1:0];
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                R_SRC_LEFT:   cfg_reg[R_SRC_LEFT]   <= cfg_wdata;
                R_SRC_TOP:    cfg_reg[R_SRC_TOP]    <= cfg_wdata;
                R_SRC_RIGHT:  cfg_reg[R_SRC_RIGHT]  <= cfg_wdata;
                R_SRC_BOTTOM: cfg_reg[R_SRC_BOTTOM] <= cfg_wdata;
                R_DST_LEFT:   cfg_reg[R_DST_LEFT]   <= cfg_wdata;
                R_DST_TOP:    cfg_reg[R_DST_TOP]    <= cfg_wdata;
                R_DST_RIGHT:  cfg_reg[R_DST_RIGHT]  <= cfg_wdata;
                R_DST_BOTTOM: cfg_reg[R_DST_BOTTOM] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance unless the output holds an untaken transaction
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    logic signed [CW-1:0] in_left, in_top, in_right, in_bottom;
    logic [2:0]           horiz_method, vert_method;
    logic [KW-1:0]        length_factor;

    assign in_left       = s_axis_tdata[CW-1:0];
    assign in_top        = s_axis_tdata[2*CW-1:CW];
    assign in_right      = s_axis_tdata[3*CW-1:2*CW];
    assign in_bottom     = s_axis_tdata[4*CW-1:3*CW];
    assign horiz_method  = s_axis_tdata[4*CW+2:4*CW];
    assign vert_method   = s_axis_tdata[4*CW+5:4*CW+3];
    assign length_factor = s_axis_tdata[4*CW+5+KW:4*CW+6];

    logic signed [CW-1:0] x_lo, x_hi, y_lo, y_hi;
    lane_flags_t          fx, fy;

    rstu_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane_x (
        .clk    (clk),
        .en     (en),
        .in_lo  (in_left),
        .in_hi  (in_right),
        .src_lo (cfg_reg[R_SRC_LEFT]),
        .src_hi (cfg_reg[R_SRC_RIGHT]),
        .dst_lo (cfg_reg[R_DST_LEFT]),
        .dst_hi (cfg_reg[R_DST_RIGHT]),
        .method (horiz_method),
        .k      (length_factor),
        .out_lo (x_lo),
        .out_hi (x_hi),
        .flags  (fx)
    );

    rstu_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane_y (
        .clk    (clk),
        .en     (en),
        .in_lo  (in_top),
        .in_hi  (in_bottom),
        .src_lo (cfg_reg[R_SRC_TOP]),
        .src_hi (cfg_reg[R_SRC_BOTTOM]),
        .dst_lo (cfg_reg[R_DST_TOP]),
        .dst_hi (cfg_reg[R_DST_BOTTOM]),
        .method (vert_method),
        .k      (length_factor),
        .out_lo (y_lo),
        .out_hi (y_hi),
        .flags  (fy)
    );

    rstu_merge #(.CW(CW), .OW(OW)) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (vld_reg[LAT-1]),
        .x_lo   (x_lo),
        .x_hi   (x_hi),
        .y_lo   (y_lo),
        .y_hi   (y_hi),
        .fx     (fx),
        .fy     (fy),
        .tvalid (m_axis_tvalid),
        .tdata  (m_axis_tdata),
        .tuser  (m_axis_tuser)
    );

    `RSTU_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "rejected rectangle carries coordinates")
    `RSTU_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3, "undefined status code")
    `RSTU_ASSERT_IMPL(a_out_source, m_axis_tvalid && !$past(m_axis_tvalid), $past(vld_reg[LAT-1]), "result without an item in flight")

endmodule
